// ----- design/shp_pkg.sv -----
// Shared types and constants of the 3x3 cross sharpen block.
package shp_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int CHANNELS   = 3;
    localparam int CH_W       = 8;
    localparam int CH_FIELDS  = 3;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int PIX_W      = CHANNELS * CH_W;
    localparam int IN_DATA_W  = CH_FIELDS * CH_W;
    localparam int OUT_DATA_W = 48;
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int PADDR_W    = 3;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

    // register index, taken from paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // result slots one input can produce, in emission order
    localparam int SLOT_CENTRE       = 0;
    localparam int SLOT_RIGHT        = 1;
    localparam int SLOT_BOTTOM       = 2;
    localparam int SLOT_BOTTOM_RIGHT = 3;
    localparam int SLOTS             = 4;

    typedef logic [CHANNELS-1:0][CH_W-1:0] pix_t;

    typedef struct packed {
        pix_t centre;
        pix_t left;
        pix_t right;
        pix_t up;
        pix_t down;
    } taps_t;

    typedef struct packed {
        pix_t               pix;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [SLOTS-1:0]   mask;
    } rec_t;

endpackage

// ----- design/shp_lane.sv -----
// One channel of the cross sharpen: 5*centre minus four neighbors, clamped to 0..255.
module shp_lane
(
    input  logic [shp_pkg::CH_W-1:0] centre,
    input  logic [shp_pkg::CH_W-1:0] left,
    input  logic [shp_pkg::CH_W-1:0] right,
    input  logic [shp_pkg::CH_W-1:0] up,
    input  logic [shp_pkg::CH_W-1:0] down,
    output logic [shp_pkg::CH_W-1:0] sharp
);

    logic [shp_pkg::CH_W+2:0]        five;
    logic [shp_pkg::CH_W+1:0]        around;
    logic signed [shp_pkg::CH_W+3:0] diff;

    always_comb
    begin
        five   = {1'b0, centre, 2'b00} + {3'b000, centre};
        around = {2'b00, left} + {2'b00, right} + {2'b00, up} + {2'b00, down};
        diff   = $signed({1'b0, five}) - $signed({2'b00, around});
        priority if (diff < 0)
        begin
            sharp = '0;
        end
        else if (diff > $signed({4'b0000, {shp_pkg::CH_W{1'b1}}}))
        begin
            sharp = '1;
        end
        else
        begin
            sharp = diff[shp_pkg::CH_W-1:0];
        end
    end

endmodule

// ----- design/shp_linebuf.sv -----
// Two line stores in one memory plus the window registers that feed the lanes.
module shp_linebuf
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [shp_pkg::ADDR_W-1:0] rd_addr,
    input  logic                       wr_en,
    input  logic [shp_pkg::ADDR_W-1:0] wr_addr,
    input  shp_pkg::pix_t              wr_px,
    output shp_pkg::taps_t             taps
);

    logic [2*shp_pkg::PIX_W-1:0] line_mem [shp_pkg::MAX_WIDTH];
    logic [2*shp_pkg::PIX_W-1:0] rdata_reg;

    shp_pkg::pix_t up_now;
    shp_pkg::pix_t mid_now;
    shp_pkg::pix_t win_up_reg;
    shp_pkg::pix_t win_mid_reg;
    shp_pkg::pix_t win_mid_old_reg;
    shp_pkg::pix_t win_bot_reg;

    assign up_now  = rdata_reg[2*shp_pkg::PIX_W-1:shp_pkg::PIX_W];
    assign mid_now = rdata_reg[shp_pkg::PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= line_mem[rd_addr];
        end
        if (wr_en)
        begin
            line_mem[wr_addr] <= {mid_now, wr_px};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_up_reg      <= '0;
            win_mid_reg     <= '0;
            win_mid_old_reg <= '0;
            win_bot_reg     <= '0;
        end
        else if (wr_en)
        begin
            win_up_reg      <= up_now;
            win_mid_old_reg <= win_mid_reg;
            win_mid_reg     <= mid_now;
            win_bot_reg     <= wr_px;
        end
    end

    assign taps.centre = win_mid_reg;
    assign taps.left   = win_mid_old_reg;
    assign taps.right  = mid_now;
    assign taps.up     = win_up_reg;
    assign taps.down   = win_bot_reg;

endmodule

// ----- design/shp_resq.sv -----
// Result queue: holds per-input records and expands each into its result transfers.
module shp_resq
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  shp_pkg::rec_t                     push_rec,
    input  logic [shp_pkg::COL_W-1:0]         last_col,
    output logic [shp_pkg::QCNT_W-1:0]        count,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [shp_pkg::OUT_DATA_W-1:0]    m_axis_tdata, // chan_zero_out, chan_one_out, chan_two_out, pixel_column, pixel_row, zero pad
    output logic                              m_axis_tlast
);

    shp_pkg::rec_t                q_mem [shp_pkg::QDEPTH];
    logic [shp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [shp_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [shp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [shp_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [shp_pkg::QCNT_W-1:0]   count_reg;
    logic [shp_pkg::QCNT_W-1:0]   count_next;
    logic [shp_pkg::SLOTS-1:0]    done_reg;
    logic [shp_pkg::SLOTS-1:0]    done_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    shp_pkg::pix_t                out_pix_reg;
    logic [shp_pkg::COL_W-1:0]    out_col_reg;
    logic [shp_pkg::ROW_W-1:0]    out_row_reg;
    logic                         out_last_reg;

    shp_pkg::rec_t                head;
    logic [shp_pkg::SLOTS-1:0]    rem;
    logic [shp_pkg::SLOTS-1:0]    sel;
    logic                         load;
    logic                         pop;
    logic                         sel_last;
    shp_pkg::pix_t                sel_pix;
    logic [shp_pkg::COL_W-1:0]    sel_col;
    logic [shp_pkg::ROW_W-1:0]    sel_row;

    assign head     = q_mem[rd_ptr_reg];
    assign rem      = head.mask & ~done_reg;
    assign sel      = rem & (~rem + shp_pkg::SLOTS'(1));
    assign sel_last = (rem & ~sel) == '0;
    assign load     = (count_reg != '0) && (!out_valid_reg || m_axis_tready);
    assign pop      = load && sel_last;

    always_comb
    begin
        sel_pix = '0;
        sel_col = head.col;
        sel_row = head.row;
        priority if (sel[shp_pkg::SLOT_CENTRE])
        begin
            sel_pix = head.pix;
        end
        else if (sel[shp_pkg::SLOT_RIGHT])
        begin
            sel_col = last_col;
        end
        else if (sel[shp_pkg::SLOT_BOTTOM])
        begin
            sel_row = head.row + shp_pkg::ROW_W'(1);
        end
        else
        begin
            sel_col = last_col;
            sel_row = head.row + shp_pkg::ROW_W'(1);
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        done_next   = done_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == shp_pkg::QPTR_W'(shp_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + shp_pkg::QPTR_W'(1);
        end
        if (load)
        begin
            done_next = done_reg | sel;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == shp_pkg::QPTR_W'(shp_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + shp_pkg::QPTR_W'(1);
            done_next   = '0;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + shp_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - shp_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
        out_valid_next = load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_rec;
        end
        if (load)
        begin
            out_pix_reg  <= sel_pix;
            out_col_reg  <= sel_col;
            out_row_reg  <= sel_row;
            out_last_reg <= sel_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < shp_pkg::CH_FIELDS; k++)
        begin : g_chan
            if (k < shp_pkg::CHANNELS)
            begin : g_used
                assign m_axis_tdata[k*shp_pkg::CH_W +: shp_pkg::CH_W] = out_pix_reg[k];
            end
            else
            begin : g_unused
                assign m_axis_tdata[k*shp_pkg::CH_W +: shp_pkg::CH_W] = '0;
            end
        end
    endgenerate

    localparam int COL_LO = shp_pkg::CH_FIELDS * shp_pkg::CH_W;
    localparam int ROW_LO = COL_LO + shp_pkg::COL_W;
    localparam int PAD_LO = ROW_LO + shp_pkg::ROW_W;

    assign m_axis_tdata[COL_LO +: shp_pkg::COL_W]                  = out_col_reg;
    assign m_axis_tdata[ROW_LO +: shp_pkg::ROW_W]                  = out_row_reg;
    assign m_axis_tdata[shp_pkg::OUT_DATA_W-1:PAD_LO]              = '0;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign count         = count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= shp_pkg::QCNT_W'(shp_pkg::QDEPTH))
        else $error("result queue count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != shp_pkg::QCNT_W'(shp_pkg::QDEPTH))
        else $error("push into full result queue");

    a_head_live: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> (head.mask != '0) && ((done_reg & ~head.mask) == '0))
        else $error("head record has no pending result");
`endif

endmodule

// ----- design/sharpen_3x3_stencil_top.sv -----
// Top level of the 3x3 cross sharpen over a raster stream of three-channel pixels.
// Takes one pixel per clock on s_axis while the result queue has room and delivers one
// result per clock on m_axis while m_axis_tready is high; an input in row 0 or column 0
// yields no result, any other input yields one, or two in the last column or the last
// row, and the last input of a frame yields four, so the output port, one transfer per
// cycle, sets the rate there. A pixel passes the line store read, lane compute and queue
// before the output register. Each result carries its own column and row; tlast marks
// the last result caused by one input. Writing either size register restarts the frame.
module sharpen_3x3_stencil_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [shp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // chan_zero_in, chan_one_in,
                                                             // chan_two_in
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [shp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // chan_zero_out, chan_one_out,
                                                             // chan_two_out, pixel_column,
                                                             // pixel_row, zero pad
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shp_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [shp_pkg::WIDTH_W-1:0]   width_reg;
    logic [shp_pkg::HEIGHT_W-1:0]  height_reg;
    logic [shp_pkg::COL_W-1:0]     col_reg;
    logic [shp_pkg::COL_W-1:0]     col_next;
    logic [shp_pkg::ROW_W-1:0]     row_reg;
    logic [shp_pkg::ROW_W-1:0]     row_next;

    logic                          s1_valid_reg;
    shp_pkg::pix_t                 s1_px_reg;
    logic [shp_pkg::COL_W-1:0]     s1_col_reg;
    logic [shp_pkg::ROW_W-1:0]     s1_row_reg;
    logic [shp_pkg::SLOTS-1:0]     s1_mask_reg;
    logic                          s1_sharp_reg;

    logic                          s2_valid_reg;
    shp_pkg::rec_t                 s2_rec_reg;

    logic                          cfg_write;
    logic [shp_pkg::WIDTH_W-1:0]   used_w;
    logic [shp_pkg::HEIGHT_W-1:0]  used_h;
    logic [shp_pkg::COL_W-1:0]     wm1;
    logic [shp_pkg::ROW_W-1:0]     hm1;
    logic [shp_pkg::COL_W-1:0]     cur_c;
    logic [shp_pkg::ROW_W-1:0]     cur_r;
    logic                          accept;
    shp_pkg::pix_t                 in_px;
    logic [shp_pkg::SLOTS-1:0]     in_mask;
    logic                          c_ge1;
    logic                          r_ge1;
    logic                          c_last;
    logic                          r_last;
    logic [shp_pkg::QCNT_W-1:0]    q_count;
    logic [shp_pkg::QCNT_W:0]      inflight;
    shp_pkg::taps_t                taps;
    shp_pkg::pix_t                 lane_pix;
    shp_pkg::rec_t                 s1_rec;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == shp_pkg::REG_HEIGHT) ? {19'd0, height_reg} :
                                                           {21'd0, width_reg};

    always_comb
    begin
        priority if (width_reg < shp_pkg::WIDTH_MIN)
        begin
            used_w = shp_pkg::WIDTH_MIN;
        end
        else if (width_reg > shp_pkg::WIDTH_MAX)
        begin
            used_w = shp_pkg::WIDTH_MAX;
        end
        else
        begin
            used_w = width_reg;
        end
        priority if (height_reg < shp_pkg::HEIGHT_MIN)
        begin
            used_h = shp_pkg::HEIGHT_MIN;
        end
        else if (height_reg > shp_pkg::HEIGHT_MAX)
        begin
            used_h = shp_pkg::HEIGHT_MAX;
        end
        else
        begin
            used_h = height_reg;
        end
    end

    assign wm1   = shp_pkg::COL_W'(used_w - shp_pkg::WIDTH_W'(1));
    assign hm1   = shp_pkg::ROW_W'(used_h - shp_pkg::HEIGHT_W'(1));
    assign cur_c = (col_reg > wm1) ? wm1 : col_reg;
    assign cur_r = (row_reg > hm1) ? hm1 : row_reg;

    assign inflight      = {1'b0, q_count} + shp_pkg::QCNT_W'(s1_valid_reg)
                                           + shp_pkg::QCNT_W'(s2_valid_reg);
    assign s_axis_tready = inflight < (shp_pkg::QCNT_W + 1)'(shp_pkg::QDEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;

    genvar k;
    generate
        for (k = 0; k < shp_pkg::CHANNELS; k++)
        begin : g_in
            assign in_px[k] = s_axis_tdata[k*shp_pkg::CH_W +: shp_pkg::CH_W];
        end
    endgenerate

    assign c_ge1  = cur_c != '0;
    assign r_ge1  = cur_r != '0;
    assign c_last = cur_c == wm1;
    assign r_last = cur_r == hm1;

    always_comb
    begin
        in_mask                                     = '0;
        in_mask[shp_pkg::SLOT_CENTRE]               = r_ge1 && c_ge1;
        in_mask[shp_pkg::SLOT_RIGHT]                = r_ge1 && c_ge1 && c_last;
        in_mask[shp_pkg::SLOT_BOTTOM]               = r_last && c_ge1;
        in_mask[shp_pkg::SLOT_BOTTOM_RIGHT]         = r_last && c_ge1 && c_last;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (c_last)
            begin
                col_next = '0;
                row_next = r_last ? '0 : cur_r + shp_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = cur_c + shp_pkg::COL_W'(1);
                row_next = cur_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= shp_pkg::WIDTH_RESET;
            height_reg   <= shp_pkg::HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (paddr[2])
                    shp_pkg::REG_WIDTH:  width_reg  <= pwdata[shp_pkg::WIDTH_W-1:0];
                    shp_pkg::REG_HEIGHT: height_reg <= pwdata[shp_pkg::HEIGHT_W-1:0];
                    default:             width_reg  <= width_reg;
                endcase
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && (s1_mask_reg != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg    <= in_px;
            s1_col_reg   <= cur_c;
            s1_row_reg   <= cur_r;
            s1_mask_reg  <= in_mask;
            s1_sharp_reg <= (cur_r > shp_pkg::ROW_W'(1)) && (cur_c > shp_pkg::COL_W'(1));
        end
        if (s1_valid_reg)
        begin
            s2_rec_reg <= s1_rec;
        end
    end

    shp_linebuf u_linebuf
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (shp_pkg::ADDR_W'(cur_c)),
        .wr_en   (s1_valid_reg),
        .wr_addr (shp_pkg::ADDR_W'(s1_col_reg)),
        .wr_px   (s1_px_reg),
        .taps    (taps)
    );

    generate
        for (k = 0; k < shp_pkg::CHANNELS; k++)
        begin : g_lane
            shp_lane u_lane
            (
                .centre (taps.centre[k]),
                .left   (taps.left[k]),
                .right  (taps.right[k]),
                .up     (taps.up[k]),
                .down   (taps.down[k]),
                .sharp  (lane_pix[k])
            );
        end
    endgenerate

    assign s1_rec.pix  = s1_sharp_reg ? lane_pix : '0;
    assign s1_rec.col  = s1_col_reg - shp_pkg::COL_W'(1);
    assign s1_rec.row  = s1_row_reg - shp_pkg::ROW_W'(1);
    assign s1_rec.mask = s1_mask_reg;

    shp_resq u_resq
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (s2_valid_reg),
        .push_rec      (s2_rec_reg),
        .last_col      (wm1),
        .count         (q_count),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight <= (shp_pkg::QCNT_W + 1)'(shp_pkg::QDEPTH))
        else $error("items in flight exceed result queue depth");
`endif

endmodule

// ----- tb/sv/sharpen_3x3_stencil_top_tb.sv -----
// Self-checking testbench of the 3x3 cross sharpen block: stream stimulus, APB sizes, scoreboard.
module sharpen_3x3_stencil_top_tb;

    localparam logic [shp_pkg::PADDR_W-1:0] WIDTH_ADDR  = {shp_pkg::REG_WIDTH, 2'b00};
    localparam logic [shp_pkg::PADDR_W-1:0] HEIGHT_ADDR = {shp_pkg::REG_HEIGHT, 2'b00};
    localparam int CENTRE_GAIN  = 5;
    localparam int CHAN_MAX     = 255;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PCT     = 8;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_ITEMS   = 30;
    localparam int WIDE_ITEMS   = 12;
    localparam int TALL_ITEMS   = 60;
    localparam int TAIL_ITEMS   = 10;

    typedef struct packed {
        shp_pkg::pix_t             pix;
        logic [shp_pkg::COL_W-1:0] col;
        logic [shp_pkg::ROW_W-1:0] row;
        logic                      last;
    } sharp_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [shp_pkg::IN_DATA_W-1:0]  s_axis_tdata;   // chan_zero_in, chan_one_in, chan_two_in
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [shp_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // chan_zero_out, chan_one_out,
                                                    // chan_two_out, pixel_column,
                                                    // pixel_row, zero pad
    logic                           m_axis_tlast;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [shp_pkg::PADDR_W-1:0]    paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    sharp_result_t                  sharp_expected_q [$];
    int                             mismatch_count;
    bit                             src_idle_on;
    bit                             sink_idle_on;
    int                             sink_hold_left;

    shp_pkg::pix_t                  line_older [shp_pkg::MAX_WIDTH];
    shp_pkg::pix_t                  line_newer [shp_pkg::MAX_WIDTH];
    shp_pkg::pix_t                  win [6];
    int unsigned                    col_pos;
    int unsigned                    row_pos;
    logic [shp_pkg::WIDTH_W-1:0]    width_reg;
    logic [shp_pkg::HEIGHT_W-1:0]   height_reg;

    sharpen_3x3_stencil_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("sharpen_3x3_stencil_top_tb: done, errors");
        $finish;
    end

    function automatic shp_pkg::pix_t sharpen_cross(input shp_pkg::pix_t ctr,
                                                    input shp_pkg::pix_t lft,
                                                    input shp_pkg::pix_t rgt,
                                                    input shp_pkg::pix_t up,
                                                    input shp_pkg::pix_t dn);
        shp_pkg::pix_t res;
        int            v;
        for (int k = 0; k < shp_pkg::CHANNELS; k++)
        begin
            v = CENTRE_GAIN * int'(ctr[k]) - int'(lft[k]) - int'(rgt[k])
                - int'(up[k]) - int'(dn[k]);
            if (v < 0)
                v = 0;
            else if (v > CHAN_MAX)
                v = CHAN_MAX;
            res[k] = v[shp_pkg::CH_W-1:0];
        end
        return res;
    endfunction

    function automatic sharp_result_t make_result(input shp_pkg::pix_t p, input int unsigned c,
                                                  input int unsigned r);
        sharp_result_t res;
        res.pix  = p;
        res.col  = shp_pkg::COL_W'(c);
        res.row  = shp_pkg::ROW_W'(r);
        res.last = 1'b0;
        return res;
    endfunction

    function automatic void predict_pixel(input shp_pkg::pix_t px);
        int unsigned   w;
        int unsigned   h;
        int unsigned   c;
        int unsigned   r;
        int            n;
        shp_pkg::pix_t up_now;
        shp_pkg::pix_t mid_now;
        shp_pkg::pix_t v;
        sharp_result_t found [shp_pkg::SLOTS];
        w = {21'd0, width_reg};
        h = {19'd0, height_reg};
        if (w < 3) w = 3;
        if (w > shp_pkg::MAX_WIDTH) w = shp_pkg::MAX_WIDTH;
        if (h < 3) h = 3;
        if (h > shp_pkg::MAX_HEIGHT) h = shp_pkg::MAX_HEIGHT;
        c = col_pos;
        r = row_pos;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        up_now  = line_older[c];
        mid_now = line_newer[c];
        n = 0;
        if (r >= 1 && c >= 1)
        begin
            v = '0;
            if (r >= 2 && c >= 2)
                v = sharpen_cross(win[2], win[3], mid_now, win[0], win[4]);
            found[n] = make_result(v, c - 1, r - 1);
            n++;
            if (c == w - 1)
            begin
                found[n] = make_result('0, w - 1, r - 1);
                n++;
            end
        end
        if (r == h - 1 && c >= 1)
        begin
            found[n] = make_result('0, c - 1, r);
            n++;
            if (c == w - 1)
            begin
                found[n] = make_result('0, w - 1, r);
                n++;
            end
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            sharp_expected_q.push_back(found[i]);
        // shift the window one column, then store the new column into both lines
        win[1] = win[0];
        win[0] = up_now;
        win[3] = win[2];
        win[2] = mid_now;
        win[5] = win[4];
        win[4] = px;
        line_older[c] = mid_now;
        line_newer[c] = px;
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic shp_pkg::pix_t random_pixel();
        shp_pkg::pix_t p;
        for (int k = 0; k < shp_pkg::CHANNELS; k++)
        begin
            case ($urandom_range(9))
                0:       p[k] = 8'h00;
                1:       p[k] = 8'hFF;
                default: p[k] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic check_result();
        sharp_result_t want;
        if (sharp_expected_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b",
                     $time, m_axis_tdata, m_axis_tlast);
            mismatch_count++;
        end
        else
        begin
            want = sharp_expected_q.pop_front();
            for (int k = 0; k < shp_pkg::CHANNELS; k++)
            begin
                if (m_axis_tdata[k*shp_pkg::CH_W +: shp_pkg::CH_W] !== want.pix[k])
                begin
                    $display("%0t: channel %0d at (%0d,%0d) expected %0d actual %0d", $time,
                             k, want.row, want.col, want.pix[k],
                             m_axis_tdata[k*shp_pkg::CH_W +: shp_pkg::CH_W]);
                    mismatch_count++;
                end
            end
            if (m_axis_tdata[shp_pkg::PIX_W +: shp_pkg::COL_W] !== want.col)
            begin
                $display("%0t: pixel_column expected %0d actual %0d", $time, want.col,
                         m_axis_tdata[shp_pkg::PIX_W +: shp_pkg::COL_W]);
                mismatch_count++;
            end
            if (m_axis_tdata[shp_pkg::PIX_W+shp_pkg::COL_W +: shp_pkg::ROW_W] !== want.row)
            begin
                $display("%0t: pixel_row expected %0d actual %0d", $time, want.row,
                         m_axis_tdata[shp_pkg::PIX_W+shp_pkg::COL_W +: shp_pkg::ROW_W]);
                mismatch_count++;
            end
            if (m_axis_tdata[shp_pkg::OUT_DATA_W-1:shp_pkg::PIX_W+shp_pkg::COL_W+shp_pkg::ROW_W]
                !== '0)
            begin
                $display("%0t: pad bits expected 0 actual %b", $time,
                         m_axis_tdata[shp_pkg::OUT_DATA_W-1:
                                      shp_pkg::PIX_W+shp_pkg::COL_W+shp_pkg::ROW_W]);
                mismatch_count++;
            end
            if (m_axis_tlast !== want.last)
            begin
                $display("%0t: tlast at (%0d,%0d) expected %b actual %b", $time,
                         want.row, want.col, want.last, m_axis_tlast);
                mismatch_count++;
            end
        end
    endtask

    // handshake inputs settle between edges, so sample on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold_left--;
            end
            else if (sink_idle_on && $urandom_range(99) < IDLE_PCT)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_pixel(input shp_pkg::pix_t px);
        bit ok;
        if (src_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
        begin
            @(negedge clk);
            ok = s_axis_tready;
            @(posedge clk);
        end
        while (!ok);
        predict_pixel(px);
    endtask

    task automatic send_random_pixels(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sharp_expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [shp_pkg::PADDR_W-1:0] addr, input logic [31:0] value);
        bit ok;
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            ok = pready;
            @(posedge clk);
        end
        while (!ok);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WIDTH_ADDR)
            width_reg = value[shp_pkg::WIDTH_W-1:0];
        else
            height_reg = value[shp_pkg::HEIGHT_W-1:0];
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic test_directed_frames();
        shp_pkg::pix_t p;
        write_reg(WIDTH_ADDR, 32'd3);
        write_reg(HEIGHT_ADDR, 32'd3);
        // centre clamps high, low and passes through, one channel each
        for (int i = 0; i < 9; i++)
        begin
            if (i == 4)
                p = {8'd100, 8'd0, 8'd255};
            else
                p = {8'd100, 8'd255, 8'd0};
            send_pixel(p);
        end
        write_reg(WIDTH_ADDR, 32'd0);
        write_reg(HEIGHT_ADDR, 32'd1);
        for (int i = 0; i < 9; i++)
        begin
            if (i == 0 || i == 2 || i == 6 || i == 8)
                p = random_pixel();
            else
                p = {8'hFF, 8'hFF, 8'hFF};
            send_pixel(p);
        end
    endtask

    task automatic test_random_frames();
        int          sent;
        int          phase;
        int unsigned w;
        int unsigned h;
        int          count;
        logic [31:0] value;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w = $urandom_range(10, 3);
            h = $urandom_range(7, 3);
            if ($urandom_range(7) == 0)
                w = $urandom_range(2);
            if ($urandom_range(7) == 0)
                h = $urandom_range(2);
            if ($urandom_range(4) != 0)
            begin
                value = ($urandom_range(1) == 1) ? (($urandom & ~32'h7FF) | w) : w;
                write_reg(WIDTH_ADDR, value);
            end
            if ($urandom_range(4) != 0 || phase == 0)
            begin
                value = ($urandom_range(1) == 1) ? (($urandom & ~32'h1FFF) | h) : h;
                write_reg(HEIGHT_ADDR, value);
            end
            w = (width_reg < 3) ? 3 : {21'd0, width_reg};
            h = (height_reg < 3) ? 3 : {19'd0, height_reg};
            src_idle_on  = (phase != 2);
            sink_idle_on = (phase != 2);
            case ($urandom_range(3))
                0:       count = $urandom_range(w * h - 1, 1);
                1:       count = w * h + $urandom_range(w * h - 1, 1);
                default: count = w * h;
            endcase
            send_random_pixels(count);
            sent += count;
            phase++;
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        write_reg(WIDTH_ADDR, 32'd6);
        write_reg(HEIGHT_ADDR, 32'd5);
        sink_hold_left = 300;
        send_random_pixels(HOLD_ITEMS);
        wait_drain();
    endtask

    task automatic test_wide_frame();
        write_reg(WIDTH_ADDR, 32'hFFFF_FFFF);
        write_reg(HEIGHT_ADDR, 32'd0);
        send_random_pixels(WIDE_ITEMS);
    endtask

    task automatic test_tall_frame();
        write_reg(WIDTH_ADDR, 32'd1);
        write_reg(HEIGHT_ADDR, 32'(shp_pkg::MAX_HEIGHT));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random_pixels(TALL_ITEMS);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_random_pixels(TAIL_ITEMS);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        mismatch_count = 0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        sink_hold_left = 0;
        width_reg      = shp_pkg::WIDTH_RESET;
        height_reg     = shp_pkg::HEIGHT_RESET;
        col_pos        = 0;
        row_pos        = 0;
        for (int i = 0; i < shp_pkg::MAX_WIDTH; i++)
        begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_random_frames();
        test_backpressure();
        test_wide_frame();
        test_tall_frame();
        wait_drain();
        if (mismatch_count == 0)
            $display("sharpen_3x3_stencil_top_tb: done, clean");
        else
            $display("sharpen_3x3_stencil_top_tb: done, errors");
        $finish;
    end

endmodule

// ----- sharpen_3x3_stencil_top.f -----
design/shp_pkg.sv
design/shp_lane.sv
design/shp_linebuf.sv
design/shp_resq.sv
design/sharpen_3x3_stencil_top.sv
tb/sv/sharpen_3x3_stencil_top_tb.sv
